// ===== design/akima_curve_tangent_stream_top_defines.svh =====
// Assertion macros shared by the checker of the Akima tangent stream.
`ifndef AKIMA_CURVE_TANGENT_STREAM_TOP_DEFINES_SVH
`define AKIMA_CURVE_TANGENT_STREAM_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ACTS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ACTS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/acts_pkg.sv =====
// Shared constants, types and state encodings of the Akima tangent stream.
package acts_pkg;

	localparam int COORD_BITS_DEF = 16;
	localparam int WFRAC_BITS_DEF = 16;
	localparam int INDEX_BITS_DEF = 16;
	localparam int TAN_BITS = 19;
	localparam int FIFO_DEPTH = 2;

	typedef struct packed {
		logic last;
		logic err;
	} job_flags_t;

	typedef enum logic [2:0] {
		F_IDLE,
		F_JOB_A,
		F_JOB_B,
		F_JOB_C,
		F_JOB_ERR
	} front_state_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_CROSS,
		B_DIV,
		B_BLEND,
		B_OUT
	} back_state_t;

endpackage

// ===== design/acts_fifo.sv =====
// Small register queue that carries tangent jobs from the front to the back.
module acts_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2,
	localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1,
	localparam int CNT_BITS = $clog2(DEPTH + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [WIDTH-1:0] in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [WIDTH-1:0] out_data
);

	logic [WIDTH-1:0]    mem_q [DEPTH];
	logic [PTR_BITS-1:0] wr_ptr_q;
	logic [PTR_BITS-1:0] rd_ptr_q;
	logic [CNT_BITS-1:0] cnt_q;
	logic                do_wr;
	logic                do_rd;

	assign in_ready  = cnt_q != CNT_BITS'(DEPTH);
	assign out_valid = cnt_q != '0;
	assign do_wr     = in_valid && in_ready;
	assign do_rd     = out_valid && out_ready;
	assign out_data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// ===== design/acts_front.sv =====
// Front end: point window, point count and generation of tangent jobs.
module acts_front import acts_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF,
	parameter int INDEX_BITS = INDEX_BITS_DEF,
	localparam int VB = COORD_BITS + 4
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push,
	output logic                         full,
	input  logic signed [COORD_BITS-1:0] x_coord,
	input  logic signed [COORD_BITS-1:0] y_coord,
	input  logic                         last_point,
	output logic                         job_valid,
	input  logic                         job_ready,
	output logic [8*VB-1:0]              job_vec,
	output logic [INDEX_BITS-1:0]        job_idx,
	output job_flags_t                   job_flags
);

	logic signed [COORD_BITS-1:0] xw_q [5];
	logic signed [COORD_BITS-1:0] yw_q [5];
	logic [INDEX_BITS-1:0]        count_q;
	logic [INDEX_BITS-1:0]        k_q;
	logic                         sat_q;
	logic                         last_q;
	front_state_t                 st_q;
	front_state_t                 st_d;
	logic                         accept;
	logic                         sat_now;
	logic                         finish;
	logic signed [VB-1:0]         cx [4];
	logic signed [VB-1:0]         cy [4];
	logic signed [VB-1:0]         m1x, m1y, p0x, p0y, q1x, q1y, q2x, q2y;

	function automatic logic signed [VB-1:0] ex(input logic signed [VB-1:0] a,
		input logic signed [VB-1:0] b);
		return (a <<< 1) - b;
	endfunction

	assign full      = st_q != F_IDLE;
	assign job_valid = st_q != F_IDLE;
	assign accept    = push && !full;
	assign sat_now   = count_q == '1;
	assign finish    = job_valid && job_ready && st_d == F_IDLE;
	assign job_vec   = {m1x, m1y, p0x, p0y, q1x, q1y, q2x, q2y};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= F_IDLE;
		end else begin
			st_q <= st_d;
		end
	end

	always_comb begin
		st_d = st_q;
		unique case (st_q)
			F_IDLE: begin
				if (accept) begin
					if (last_point && !sat_now && count_q < INDEX_BITS'(3)) begin
						st_d = F_JOB_ERR;
					end else if (sat_now || count_q >= INDEX_BITS'(2)) begin
						st_d = F_JOB_A;
					end
				end
			end
			F_JOB_A: begin
				if (job_ready) begin
					st_d = last_q ? F_JOB_B : F_IDLE;
				end
			end
			F_JOB_B: begin
				if (job_ready) begin
					st_d = F_JOB_C;
				end
			end
			F_JOB_C, F_JOB_ERR: begin
				if (job_ready) begin
					st_d = F_IDLE;
				end
			end
			default: st_d = F_IDLE;
		endcase
	end

	always_comb begin
		for (int j = 0; j < 4; j++) begin
			cx[j] = VB'(xw_q[j+1]) - VB'(xw_q[j]);
			cy[j] = VB'(yw_q[j+1]) - VB'(yw_q[j]);
		end
		m1x = cx[0];
		m1y = cy[0];
		p0x = cx[1];
		p0y = cy[1];
		q1x = cx[2];
		q1y = cy[2];
		q2x = cx[3];
		q2y = cy[3];
		job_idx = sat_q ? '1 : k_q - INDEX_BITS'(2);
		job_flags = '{last: 1'b0, err: 1'b0};
		case (st_q)
			F_JOB_A: begin
				if (!sat_q && k_q == INDEX_BITS'(2)) begin
					p0x = ex(cx[2], cx[3]);
					p0y = ex(cy[2], cy[3]);
					m1x = ex(p0x, cx[2]);
					m1y = ex(p0y, cy[2]);
				end else if (!sat_q && k_q == INDEX_BITS'(3)) begin
					m1x = ex(cx[1], cx[2]);
					m1y = ex(cy[1], cy[2]);
				end
			end
			F_JOB_B: begin
				m1x = cx[1];
				m1y = cy[1];
				p0x = cx[2];
				p0y = cy[2];
				q1x = cx[3];
				q1y = cy[3];
				q2x = ex(cx[3], cx[2]);
				q2y = ex(cy[3], cy[2]);
				job_idx = sat_q ? '1 : k_q - INDEX_BITS'(1);
			end
			F_JOB_C: begin
				m1x = cx[2];
				m1y = cy[2];
				p0x = cx[3];
				p0y = cy[3];
				q1x = ex(cx[3], cx[2]);
				q1y = ex(cy[3], cy[2]);
				q2x = ex(q1x, cx[3]);
				q2y = ex(q1y, cy[3]);
				job_idx = sat_q ? '1 : k_q;
				job_flags = '{last: 1'b1, err: 1'b0};
			end
			F_JOB_ERR: begin
				m1x = '0;
				m1y = '0;
				p0x = '0;
				p0y = '0;
				q1x = '0;
				q1y = '0;
				q2x = '0;
				q2y = '0;
				job_idx = '0;
				job_flags = '{last: 1'b1, err: 1'b1};
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < 5; j++) begin
				xw_q[j] <= '0;
				yw_q[j] <= '0;
			end
			count_q <= '0;
			k_q     <= '0;
			sat_q   <= 1'b0;
			last_q  <= 1'b0;
		end else if (accept) begin
			for (int j = 0; j < 4; j++) begin
				xw_q[j] <= xw_q[j+1];
				yw_q[j] <= yw_q[j+1];
			end
			xw_q[4] <= x_coord;
			yw_q[4] <= y_coord;
			k_q     <= count_q;
			sat_q   <= sat_now;
			last_q  <= last_point;
			if (!sat_now) begin
				count_q <= count_q + 1'b1;
			end
		end else if (finish && last_q) begin
			for (int j = 0; j < 5; j++) begin
				xw_q[j] <= '0;
				yw_q[j] <= '0;
			end
			count_q <= '0;
		end
	end

endmodule

// ===== design/acts_back.sv =====
// Back end: cross products, weight division and blend on one shared multiplier.
module acts_back import acts_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF,
	parameter int WEIGHT_FRACTION_BITS = WFRAC_BITS_DEF,
	parameter int INDEX_BITS = INDEX_BITS_DEF,
	localparam int VB = COORD_BITS + 4,
	localparam int F = WEIGHT_FRACTION_BITS,
	localparam int MW = (VB > F + 2) ? VB : F + 2,
	localparam int PW = 2 * MW,
	localparam int NW = PW + 1,
	localparam int DW = NW + 1,
	localparam int DDW = DW + 1,
	localparam int QW = F + 2,
	localparam int NUMW = DW + F + 2,
	localparam int RW = DDW + 1,
	localparam int DCW = $clog2(QW)
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       job_valid,
	output logic                       job_ready,
	input  logic [8*VB-1:0]            job_vec,
	input  logic [INDEX_BITS-1:0]      job_idx,
	input  job_flags_t                 job_flags,
	output logic                       empty,
	input  logic                       pop,
	output logic signed [TAN_BITS-1:0] tangent_x,
	output logic signed [TAN_BITS-1:0] tangent_y,
	output logic [INDEX_BITS-1:0]      point_index,
	output logic                       too_few_points,
	output logic                       last_result
);

	localparam logic [F:0] W_ONE = (F + 1)'(1) << F;
	localparam logic signed [PW:0] HALF = (PW + 1)'(1) << (F - 1);

	back_state_t                st_q;
	back_state_t                st_d;
	logic [2:0]                 cnt_q;
	logic [DCW-1:0]             dcnt_q;
	logic signed [VB-1:0]       m1x_q, m1y_q, p0x_q, p0y_q, q1x_q, q1y_q, q2x_q, q2y_q;
	logic [INDEX_BITS-1:0]      idx_q;
	job_flags_t                 flags_q;
	logic signed [PW-1:0]       prod_q;
	logic signed [PW-1:0]       acc_q;
	logic [NW-1:0]              n_q;
	logic [DDW-1:0]             dd_q;
	logic [RW-1:0]              rem_q;
	logic [QW-1:0]              num_q;
	logic [QW-1:0]              q_q;
	logic [F:0]                 w_q;
	logic signed [TAN_BITS-1:0] tx_q;
	logic signed [TAN_BITS-1:0] ty_q;
	logic                       out_valid_q;
	logic signed [TAN_BITS-1:0] out_tx_q;
	logic signed [TAN_BITS-1:0] out_ty_q;
	logic [INDEX_BITS-1:0]      out_idx_q;
	logic                       out_few_q;
	logic                       out_last_q;

	logic signed [MW-1:0]       mul_a;
	logic signed [MW-1:0]       mul_b;
	logic signed [PW-1:0]       prod_d;
	logic signed [PW:0]         diff;
	logic [NW-1:0]              mag;
	logic [DW-1:0]              d_new;
	logic [NUMW-1:0]            num_full;
	logic [RW:0]                trial;
	logic                       ge;
	logic signed [PW:0]         bsum;
	logic [F:0]                 wn;
	logic                       load_out;

	assign wn       = W_ONE - w_q;
	assign prod_d   = PW'(mul_a) * PW'(mul_b);
	assign diff     = (PW + 1)'(acc_q) - (PW + 1)'(prod_q);
	assign mag      = diff[PW] ? NW'(-diff) : NW'(diff);
	assign d_new    = DW'(n_q) + DW'(mag);
	assign num_full = (NUMW'(n_q) << (F + 1)) + NUMW'(d_new);
	assign trial    = {rem_q, num_q[QW-1]};
	assign ge       = trial >= (RW + 1)'(dd_q);
	assign bsum     = (PW + 1)'(acc_q) + (PW + 1)'(prod_q) + HALF;

	assign empty          = !out_valid_q;
	assign tangent_x      = out_tx_q;
	assign tangent_y      = out_ty_q;
	assign point_index    = out_idx_q;
	assign too_few_points = out_few_q;
	assign last_result    = out_last_q;

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		if (st_q == B_CROSS) begin
			case (cnt_q)
				3'd0: begin
					mul_a = MW'(m1x_q);
					mul_b = MW'(p0y_q);
				end
				3'd1: begin
					mul_a = MW'(m1y_q);
					mul_b = MW'(p0x_q);
				end
				3'd2: begin
					mul_a = MW'(q1x_q);
					mul_b = MW'(q2y_q);
				end
				default: begin
					mul_a = MW'(q1y_q);
					mul_b = MW'(q2x_q);
				end
			endcase
		end else begin
			case (cnt_q)
				3'd0: begin
					mul_a = signed'(MW'(wn));
					mul_b = MW'(p0x_q);
				end
				3'd1: begin
					mul_a = signed'(MW'(w_q));
					mul_b = MW'(q1x_q);
				end
				3'd2: begin
					mul_a = signed'(MW'(wn));
					mul_b = MW'(p0y_q);
				end
				default: begin
					mul_a = signed'(MW'(w_q));
					mul_b = MW'(q1y_q);
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= B_IDLE;
		end else begin
			st_q <= st_d;
		end
	end

	always_comb begin
		st_d      = st_q;
		job_ready = 1'b0;
		load_out  = 1'b0;
		unique case (st_q)
			B_IDLE: begin
				job_ready = 1'b1;
				if (job_valid) begin
					st_d = job_flags.err ? B_OUT : B_CROSS;
				end
			end
			B_CROSS: begin
				if (cnt_q == 3'd4) begin
					st_d = (d_new == '0) ? B_BLEND : B_DIV;
				end
			end
			B_DIV: begin
				if (dcnt_q == DCW'(QW - 1)) begin
					st_d = B_BLEND;
				end
			end
			B_BLEND: begin
				if (cnt_q == 3'd4) begin
					st_d = B_OUT;
				end
			end
			B_OUT: begin
				if (!out_valid_q) begin
					load_out = 1'b1;
					st_d     = B_IDLE;
				end
			end
			default: st_d = B_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			dcnt_q <= '0;
		end else begin
			if (st_d != st_q) begin
				cnt_q  <= '0;
				dcnt_q <= '0;
			end else begin
				if (st_q == B_CROSS || st_q == B_BLEND) begin
					cnt_q <= cnt_q + 1'b1;
				end
				if (st_q == B_DIV) begin
					dcnt_q <= dcnt_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= prod_d;
		unique case (st_q)
			B_IDLE: begin
				if (job_valid) begin
					{m1x_q, m1y_q, p0x_q, p0y_q, q1x_q, q1y_q, q2x_q, q2y_q} <= job_vec;
					idx_q   <= job_idx;
					flags_q <= job_flags;
					tx_q    <= '0;
					ty_q    <= '0;
				end
			end
			B_CROSS: begin
				case (cnt_q)
					3'd1, 3'd3: acc_q <= prod_q;
					3'd2: n_q <= mag;
					3'd4: begin
						w_q   <= W_ONE;
						dd_q  <= {d_new, 1'b0};
						rem_q <= RW'(num_full >> QW);
						num_q <= num_full[QW-1:0];
					end
					default: begin
					end
				endcase
			end
			B_DIV: begin
				rem_q <= ge ? RW'(trial - (RW + 1)'(dd_q)) : RW'(trial);
				q_q   <= {q_q[QW-2:0], ge};
				num_q <= num_q << 1;
				if (dcnt_q == DCW'(QW - 1)) begin
					w_q <= {q_q[F-1:0], ge};
				end
			end
			B_BLEND: begin
				case (cnt_q)
					3'd1, 3'd3: acc_q <= prod_q;
					3'd2: tx_q <= TAN_BITS'(bsum >>> F);
					3'd4: ty_q <= TAN_BITS'(bsum >>> F);
					default: begin
					end
				endcase
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (pop && out_valid_q) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_tx_q   <= tx_q;
			out_ty_q   <= ty_q;
			out_idx_q  <= idx_q;
			out_few_q  <= flags_q.err;
			out_last_q <= flags_q.last;
		end
	end

endmodule

// ===== design/akima_curve_tangent_stream_top.sv =====
// Top level of the Akima tangent stream: front end, job queue and back end.
//
//   port group                         | direction | handshake
//   x_coord, y_coord, last_point       | in        | push / full
//   tangent_x, tangent_y, point_index,
//   too_few_points, last_result        | out       | empty / pop
//
// In the back end each tangent takes five steps of the shared multiplier for the
// cross products, a division to a WEIGHT_FRACTION_BITS+2-bit quotient and
// five multiplier steps for the blend. The final point of a curve yields three
// tangents, and the front end holds full high until all its jobs are queued.
// Reset is asynchronous and clears the window, the count and all control state.
// A stalled result waits in the output register while the next job is computed.
module akima_curve_tangent_stream_top import acts_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF,
	parameter int WEIGHT_FRACTION_BITS = WFRAC_BITS_DEF,
	parameter int INDEX_BITS = INDEX_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push,
	output logic                         full,
	input  logic signed [COORD_BITS-1:0] x_coord,
	input  logic signed [COORD_BITS-1:0] y_coord,
	input  logic                         last_point,
	output logic                         empty,
	input  logic                         pop,
	output logic signed [TAN_BITS-1:0]   tangent_x,
	output logic signed [TAN_BITS-1:0]   tangent_y,
	output logic [INDEX_BITS-1:0]        point_index,
	output logic                         too_few_points,
	output logic                         last_result
);

	localparam int VB = COORD_BITS + 4;
	localparam int JW = 8 * VB + INDEX_BITS + $bits(job_flags_t);

	logic                  fr_valid;
	logic                  fr_ready;
	logic [8*VB-1:0]       fr_vec;
	logic [INDEX_BITS-1:0] fr_idx;
	job_flags_t            fr_flags;
	logic                  bk_valid;
	logic                  bk_ready;
	logic [JW-1:0]         bk_data;
	logic [8*VB-1:0]       bk_vec;
	logic [INDEX_BITS-1:0] bk_idx;
	job_flags_t            bk_flags;

	assign {bk_vec, bk_idx, bk_flags} = bk_data;

	acts_front #(
		.COORD_BITS(COORD_BITS),
		.INDEX_BITS(INDEX_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.x_coord   (x_coord),
		.y_coord   (y_coord),
		.last_point(last_point),
		.job_valid (fr_valid),
		.job_ready (fr_ready),
		.job_vec   (fr_vec),
		.job_idx   (fr_idx),
		.job_flags (fr_flags)
	);

	acts_fifo #(
		.WIDTH(JW),
		.DEPTH(FIFO_DEPTH)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (fr_valid),
		.in_ready (fr_ready),
		.in_data  ({fr_vec, fr_idx, fr_flags}),
		.out_valid(bk_valid),
		.out_ready(bk_ready),
		.out_data (bk_data)
	);

	acts_back #(
		.COORD_BITS          (COORD_BITS),
		.WEIGHT_FRACTION_BITS(WEIGHT_FRACTION_BITS),
		.INDEX_BITS          (INDEX_BITS)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.job_valid     (bk_valid),
		.job_ready     (bk_ready),
		.job_vec       (bk_vec),
		.job_idx       (bk_idx),
		.job_flags     (bk_flags),
		.empty         (empty),
		.pop           (pop),
		.tangent_x     (tangent_x),
		.tangent_y     (tangent_y),
		.point_index   (point_index),
		.too_few_points(too_few_points),
		.last_result   (last_result)
	);

endmodule

// ===== design/acts_checker.sv =====
// Port-level checker of the Akima tangent stream and its bind to the top level.
`include "akima_curve_tangent_stream_top_defines.svh"

module acts_checker import acts_pkg::*; #(
	parameter int COORD_BITS = COORD_BITS_DEF,
	parameter int INDEX_BITS = INDEX_BITS_DEF
) (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         push,
	input logic                         full,
	input logic signed [COORD_BITS-1:0] x_coord,
	input logic signed [COORD_BITS-1:0] y_coord,
	input logic                         last_point,
	input logic                         empty,
	input logic                         pop,
	input logic signed [TAN_BITS-1:0]   tangent_x,
	input logic signed [TAN_BITS-1:0]   tangent_y,
	input logic [INDEX_BITS-1:0]        point_index,
	input logic                         too_few_points,
	input logic                         last_result
);

	`ACTS_ASSERT_NOW(a_few_is_last, !empty && too_few_points, last_result, "short curve word is not last")
	`ACTS_ASSERT_NOW(a_few_is_zero, !empty && too_few_points, tangent_x == 0 && tangent_y == 0 && point_index == 0, "short curve word has nonzero fields")
	`ACTS_ASSERT_NOW(a_last_index, !empty && last_result && !too_few_points, point_index != 0, "final tangent of a curve has index zero")
	`ACTS_ASSERT_NEXT(a_hold, !empty && !pop, !empty && $stable(tangent_x) && $stable(tangent_y) && $stable(point_index), "waiting word changed")

endmodule

bind akima_curve_tangent_stream_top acts_checker #(
	.COORD_BITS(COORD_BITS),
	.INDEX_BITS(INDEX_BITS)
) u_acts_checker (.*);

// ===== verif/testbench.sv =====
// Self-checking testbench for the Akima curve tangent stream with a scoreboard class.
typedef struct {
	longint x;
	longint y;
} chord_t;

typedef struct {
	logic signed [18:0] tx;
	logic signed [18:0] ty;
	logic [15:0]        idx;
	logic               few;
	logic               last;
} tangent_word_t;

class tangent_scoreboard;
	localparam longint W_ONE = 64'sd1 << 16;
	localparam int unsigned IDX_MAX = 65535;

	longint xw[5];
	longint yw[5];
	int unsigned count;
	tangent_word_t awaited[$];
	int errors;

	function new();
		clear_curve();
		errors = 0;
	endfunction

	function void clear_curve();
		for (int j = 0; j < 5; j++) begin
			xw[j] = 0;
			yw[j] = 0;
		end
		count = 0;
	endfunction

	function chord_t seg(int j);
		chord_t c;
		c.x = xw[j+1] - xw[j];
		c.y = yw[j+1] - yw[j];
		return c;
	endfunction

	function chord_t extend(chord_t a, chord_t b);
		chord_t r;
		r.x = 2*a.x - b.x;
		r.y = 2*a.y - b.y;
		return r;
	endfunction

	function longint cross_abs(chord_t a, chord_t b);
		longint c;
		c = a.x*b.y - a.y*b.x;
		return (c < 0) ? -c : c;
	endfunction

	function longint mix(longint p0, longint p1, longint w);
		longint v;
		v = (W_ONE - w)*p0 + w*p1 + (W_ONE >>> 1);
		return v >>> 16;
	endfunction

	function void add_tangent(chord_t qm1, chord_t qp0, chord_t qp1, chord_t qp2,
			int unsigned idx, bit last);
		longint n, d, w, tx, ty;
		tangent_word_t r;
		n = cross_abs(qm1, qp0);
		d = n + cross_abs(qp1, qp2);
		w = W_ONE;
		if (d > 0) begin
			w = ((n << 17) + d) / (2*d);
		end
		tx = mix(qp0.x, qp1.x, w);
		ty = mix(qp0.y, qp1.y, w);
		r.tx = tx[18:0];
		r.ty = ty[18:0];
		r.idx = idx[15:0];
		r.few = 1'b0;
		r.last = last;
		awaited.push_back(r);
	endfunction

	function void note_point(logic signed [15:0] x, logic signed [15:0] y, bit last);
		bit sat;
		int unsigned k;
		chord_t c0, c1, c2, c3, m1, p0, p2, q1;
		tangent_word_t r;
		sat = (count >= IDX_MAX);
		k = count;
		for (int j = 0; j < 4; j++) begin
			xw[j] = xw[j+1];
			yw[j] = yw[j+1];
		end
		xw[4] = x;
		yw[4] = y;
		if (!sat) begin
			count++;
		end
		if (last && !sat && k < 3) begin
			r.tx = '0;
			r.ty = '0;
			r.idx = '0;
			r.few = 1'b1;
			r.last = 1'b1;
			awaited.push_back(r);
			clear_curve();
			return;
		end
		c0 = seg(0);
		c1 = seg(1);
		c2 = seg(2);
		c3 = seg(3);
		if (sat || k >= 2) begin
			m1 = c0;
			p0 = c1;
			if (!sat && k == 2) begin
				p0 = extend(c2, c3);
				m1 = extend(p0, c2);
			end else if (!sat && k == 3) begin
				m1 = extend(c1, c2);
			end
			add_tangent(m1, p0, c2, c3, sat ? IDX_MAX : k - 2, 1'b0);
		end
		if (last) begin
			p2 = extend(c3, c2);
			add_tangent(c1, c2, c3, p2, sat ? IDX_MAX : k - 1, 1'b0);
			q1 = extend(c3, c2);
			add_tangent(c2, c3, q1, extend(q1, c3), sat ? IDX_MAX : k, 1'b1);
			clear_curve();
		end
	endfunction

	function void check_result(tangent_word_t got);
		tangent_word_t e;
		if (awaited.size() == 0) begin
			errors++;
			if (errors <= 10) begin
				$display("unexpected word: tx=%0d ty=%0d idx=%0d few=%0b last=%0b",
					got.tx, got.ty, got.idx, got.few, got.last);
			end
			return;
		end
		e = awaited.pop_front();
		if (got.tx !== e.tx || got.ty !== e.ty || got.idx !== e.idx ||
				got.few !== e.few || got.last !== e.last) begin
			errors++;
			if (errors <= 10) begin
				$display("word mismatch: expected tx=%0d ty=%0d idx=%0d few=%0b last=%0b",
					e.tx, e.ty, e.idx, e.few, e.last);
				$display("                 actual tx=%0d ty=%0d idx=%0d few=%0b last=%0b",
					got.tx, got.ty, got.idx, got.few, got.last);
			end
		end
	endfunction
endclass

module testbench;
	import acts_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam longint CYCLE_LIMIT = 20000000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic full;
	logic signed [15:0] x_coord = '0;
	logic signed [15:0] y_coord = '0;
	logic last_point = 1'b0;
	logic empty;
	logic pop = 1'b0;
	logic signed [TAN_BITS-1:0] tangent_x;
	logic signed [TAN_BITS-1:0] tangent_y;
	logic [15:0] point_index;
	logic too_few_points;
	logic last_result;

	tangent_scoreboard board = new();
	bit gaps_on = 1'b1;
	longint cycles = 0;

	akima_curve_tangent_stream_top DUT (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full),
		.x_coord(x_coord), .y_coord(y_coord), .last_point(last_point),
		.empty(empty), .pop(pop), .tangent_x(tangent_x), .tangent_y(tangent_y),
		.point_index(point_index), .too_few_points(too_few_points),
		.last_result(last_result)
	);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		tangent_word_t got;
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("akima_curve_tangent_stream_top regression: fail");
			$finish;
		end
		if (arst_n && push && !full) begin
			board.note_point(x_coord, y_coord, last_point);
		end
		if (arst_n && pop && !empty) begin
			got.tx = tangent_x;
			got.ty = tangent_y;
			got.idx = point_index;
			got.few = too_few_points;
			got.last = last_result;
			board.check_result(got);
		end
	end

	initial begin
		int n;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (gaps_on && $urandom_range(0, 7) == 0) begin
				n = $urandom_range(1, 10);
				pop = 1'b0;
				repeat (n - 1) @(negedge clk);
			end else begin
				pop = 1'b1;
			end
		end
	end

	task automatic send_point(logic signed [15:0] x, logic signed [15:0] y, bit last);
		int n;
		@(negedge clk);
		if (gaps_on && $urandom_range(0, 7) == 0) begin
			n = $urandom_range(1, 10);
			push = 1'b0;
			repeat (n) @(negedge clk);
		end
		push = 1'b1;
		x_coord = x;
		y_coord = y;
		last_point = last;
		do @(posedge clk); while (full);
	endtask

	function automatic logic [15:0] pick_coord(int mode);
		case (mode)
			0: return 16'($urandom);
			1: return 16'($urandom_range(0, 6) - 3);
			2: return $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
			default: return 16'($urandom_range(0, 400) - 200);
		endcase
	endfunction

	task automatic send_curve(int len, int mode);
		for (int i = 0; i < len; i++) begin
			send_point(pick_coord(mode), pick_coord(mode), i == len - 1);
		end
	endtask

	initial begin
		int len;
		arst_n = 1'b0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		send_point(16'sd5, -16'sd7, 1'b1);
		send_point(16'sd1, 16'sd2, 1'b0);
		send_point(16'sd3, 16'sd4, 1'b1);
		send_curve(3, 0);
		for (int i = 0; i < 4; i++) begin
			send_point(16'(10 * i), 16'(20 * i), i == 3);
		end
		for (int i = 0; i < 4; i++) begin
			send_point(16'sd9, -16'sd9, i == 3);
		end
		send_point(16'sh7fff, 16'sh8000, 1'b0);
		send_point(16'sh8000, 16'sh7fff, 1'b0);
		send_point(16'sh7fff, 16'sh7fff, 1'b0);
		send_point(16'sh8000, 16'sh8000, 1'b0);
		send_point(16'sh7fff, 16'sh8000, 1'b1);

		for (int c = 0; c < 66; c++) begin
			if ($urandom_range(0, 9) == 0) begin
				len = $urandom_range(1, 3);
			end else begin
				len = $urandom_range(4, 10);
			end
			send_curve(len, $urandom_range(0, 3));
			if (c == 50) begin
				gaps_on = 1'b0;
			end
		end

		send_curve(2, 0);
		send_curve(5, 0);

		@(negedge clk);
		push = 1'b0;
		while (board.awaited.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (board.errors == 0) begin
			$display("akima_curve_tangent_stream_top regression: pass");
		end else begin
			$display("akima_curve_tangent_stream_top regression: fail");
		end
		$finish;
	end
endmodule

// ===== files.f =====
+incdir+design
design/acts_pkg.sv
design/acts_fifo.sv
design/acts_front.sv
design/acts_back.sv
design/akima_curve_tangent_stream_top.sv
design/acts_checker.sv
verif/testbench.sv
